// ----- hdl/rxt_pkg.sv -----
`timescale 1ns / 1ps
// Package for the rectangle exclusion table: item structs, operation codes,
// the probe that walks the cell chain, and table sizing. No dependencies.
package rxt_pkg;

   // Table sizing
   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int SLOT_W        = 6;
   localparam int COORD_W       = 16;
   localparam int SCREEN_W      = 15;

   // Configuration register indexes
   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   // Screen size after reset
   localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 15'd640;
   localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 15'd480;

   // Operation codes
   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_CLEAR  = 2'd1,
      FUNC_QUERY  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   // Input item
   typedef struct packed {
      logic [1:0]                func;
      logic signed [COORD_W-1:0] rect_left;
      logic signed [COORD_W-1:0] rect_top;
      logic signed [COORD_W-1:0] rect_right;
      logic signed [COORD_W-1:0] rect_bottom;
      logic signed [COORD_W-1:0] slot_handle;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
   } req_type;

   // Result item
   typedef struct packed {
      logic [SLOT_W-1:0] slot_out;
      logic              op_ok;
      logic              in_field;
   } rsp_type;

   // One table entry
   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] bottom;
   } rect_type;

   // Probe handed from cell to cell; done means slot taken (insert) or hit or point off screen (query)
   typedef struct packed {
      logic                      active;
      func_type                  func;
      rect_type                  rect;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic                      handle_ok;
      logic [IDX_W-1:0]          handle_idx;
      logic                      done;
      logic [IDX_W-1:0]          slot;
   } probe_type;

endpackage

// ----- hdl/rxt_cell.sv -----
`timescale 1ns / 1ps
// One cell of the exclusion table chain: holds one rectangle and applies the
// passing probe to it. Depends on rxt_pkg.
module rxt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [rxt_pkg::IDX_W-1:0] cell_index,
   input  rxt_pkg::probe_type      probe_i,
   output rxt_pkg::probe_type      probe_o
);

   rxt_pkg::rect_type  entry_ff, entry_in;
   rxt_pkg::probe_type probe_ff, probe_in;
   logic               empty;
   logic               hit;

   // Entry state and point test
   assign empty = (entry_ff.left == '0) && (entry_ff.top == '0) &&
                  (entry_ff.right == '0) && (entry_ff.bottom == '0);
   assign hit   = !empty &&
                  (probe_i.point_x >= entry_ff.left) && (probe_i.point_x <= entry_ff.right) &&
                  (probe_i.point_y >= entry_ff.top)  && (probe_i.point_y <= entry_ff.bottom);

   // Apply the probe to this entry
   always_comb begin
      probe_in = probe_i;
      entry_in = entry_ff;
      if (probe_i.active) begin
         unique case (probe_i.func)
            rxt_pkg::FUNC_INSERT: begin
               if (!probe_i.done && empty) begin
                  entry_in      = probe_i.rect;
                  probe_in.done = 1'b1;
                  probe_in.slot = cell_index;
               end
            end
            rxt_pkg::FUNC_CLEAR: begin
               if (probe_i.handle_ok && (probe_i.handle_idx == cell_index)) begin
                  entry_in = '0;
               end
            end
            rxt_pkg::FUNC_QUERY: begin
               if (!probe_i.done && hit) begin
                  probe_in.done = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Entry and outgoing probe registers
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         probe_ff <= '0;
      end else begin
         entry_ff <= entry_in;
         probe_ff <= probe_in;
      end
   end

   assign probe_o = probe_ff;

endmodule

// ----- hdl/rect_exclusion_table_top.sv -----
`timescale 1ns / 1ps
// Top level of the rectangle exclusion table: command port, screen size
// registers and the chain of rxt_cell. Depends on rxt_pkg and rxt_cell.
//
//   channel   ports                               handshake
//   -------   ---------------------------------   ------------------------------
//   request   start, busy, req_data               taken when start && !busy
//   result    rsp_valid, rsp_data                 one-cycle strobe, no backpressure
//   config    csr_we, csr_index, csr_wdata        written when csr_we
//
// Each item walks the chain of TABLE_ENTRIES cells, one cell per cycle, and its
// result is shown as its probe leaves the tail cell. busy drops in the cycle
// the result is shown, so a new item may be taken then. The chain holds one
// item at a time. Synchronous reset empties every entry and restores a
// 640 x 480 screen. The receiver cannot stall the result.
module rect_exclusion_table_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  rxt_pkg::req_type             req_data,
   output logic                         rsp_valid,
   output rxt_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [rxt_pkg::SCREEN_W-1:0] csr_wdata
);

   logic                         busy_ff, busy_in;
   logic [rxt_pkg::SCREEN_W-1:0] width_ff, width_in;
   logic [rxt_pkg::SCREEN_W-1:0] height_ff, height_in;
   logic                         accept;
   logic                         off_screen;
   rxt_pkg::probe_type           inject;
   rxt_pkg::probe_type           probe_vec [rxt_pkg::TABLE_ENTRIES];
   rxt_pkg::probe_type           last;
   logic [rxt_pkg::TABLE_ENTRIES-1:0] active_vec;

   // busy_ff covers the item from accept to its result; the result cycle is open
   assign busy   = busy_ff && !rsp_valid;
   assign accept = start && !busy;

   // Screen bounds check, done once at accept
   assign off_screen =
      req_data.point_x[rxt_pkg::COORD_W-1] || req_data.point_y[rxt_pkg::COORD_W-1] ||
      (req_data.point_x >= $signed({1'b0, width_ff})) ||
      (req_data.point_y >= $signed({1'b0, height_ff}));

   // Build the probe for the head of the chain
   always_comb begin
      inject            = '0;
      inject.active     = accept;
      inject.func       = rxt_pkg::func_type'(req_data.func);
      inject.rect.left  = req_data.rect_left;
      inject.rect.top   = req_data.rect_top;
      inject.rect.right = req_data.rect_right;
      inject.rect.bottom = req_data.rect_bottom;
      inject.point_x    = req_data.point_x;
      inject.point_y    = req_data.point_y;
      inject.handle_ok  = !req_data.slot_handle[rxt_pkg::COORD_W-1] &&
                          (req_data.slot_handle <
                           $signed(rxt_pkg::COORD_W'(rxt_pkg::TABLE_ENTRIES)));
      inject.handle_idx = req_data.slot_handle[rxt_pkg::IDX_W-1:0];
      inject.done       = (rxt_pkg::func_type'(req_data.func) == rxt_pkg::FUNC_QUERY) &&
                          off_screen;
   end

   // Cell chain
   for (genvar k = 0; k < rxt_pkg::TABLE_ENTRIES; k++) begin : g_cell
      if (k == 0) begin : g_head
         rxt_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (rxt_pkg::IDX_W'(k)),
            .probe_i    (inject),
            .probe_o    (probe_vec[k])
         );
      end else begin : g_body
         rxt_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (rxt_pkg::IDX_W'(k)),
            .probe_i    (probe_vec[k-1]),
            .probe_o    (probe_vec[k])
         );
      end
      assign active_vec[k] = probe_vec[k].active;
   end

   assign last = probe_vec[rxt_pkg::TABLE_ENTRIES-1];

   // Result from the probe leaving the tail cell
   always_comb begin
      rsp_valid = last.active;
      rsp_data  = '0;
      unique case (last.func)
         rxt_pkg::FUNC_INSERT: begin
            rsp_data.op_ok    = last.done;
            rsp_data.slot_out = last.done ? rxt_pkg::SLOT_W'(last.slot) : '0;
         end
         rxt_pkg::FUNC_CLEAR: begin
            rsp_data.op_ok = last.handle_ok;
         end
         rxt_pkg::FUNC_QUERY: begin
            rsp_data.op_ok    = 1'b1;
            rsp_data.in_field = !last.done;
         end
         default: begin
         end
      endcase
   end

   // Busy and configuration next values
   always_comb begin
      busy_in   = busy_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (rsp_valid) begin
         busy_in = 1'b0;
      end
      if (csr_we) begin
         if (csr_index == rxt_pkg::CSR_SCREEN_WIDTH) begin
            width_in = csr_wdata;
         end else begin
            height_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         width_ff  <= rxt_pkg::SCREEN_WIDTH_RST;
         height_ff <= rxt_pkg::SCREEN_HEIGHT_RST;
      end else begin
         busy_ff   <= busy_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Checks
   a_one_probe: assert property (@(posedge clock) disable iff (reset)
      $onehot0(active_vec))
      else $error("more than one item in the cell chain");

   a_enter_head: assert property (@(posedge clock) disable iff (reset)
      accept |=> active_vec[0] && busy_ff)
      else $error("accepted item did not enter the chain");

   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy_ff)
      else $error("result shown with no item outstanding");

   a_busy_tracks_chain: assert property (@(posedge clock) disable iff (reset)
      (|active_vec) && !rsp_valid |-> busy_ff)
      else $error("item in chain while not busy");

endmodule
